/* rtl/core/hav_pkg.sv */
// hav_pkg: shared widths, constants and the CORDIC arctangent table
// for the haversine distance unit. No dependencies.
package hav_pkg;

    localparam int F          = 30;
    localparam int STEPS      = 32;
    localparam int DW         = F + 4;            // CORDIC datapath width, signed
    localparam int HALF_W     = 34;               // half-unit angle width, signed
    localparam int RAD_W      = 23;
    localparam int DIST_W     = 35;

    localparam logic signed [HALF_W-1:0] FULL_TURN    = 34'sd7200000000;
    localparam logic signed [HALF_W-1:0] HALF_TURN    = 34'sd3600000000;
    localparam logic signed [HALF_W-1:0] QUARTER_TURN = 34'sd1800000000;

    localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C235;
    localparam logic [63:0] QPI_Q62   = 64'h3243F6A8885A308D;
    localparam logic [63:0] GAIN_Q62  = 64'd2800459870029452953;
    localparam logic [63:0] DEG_MUL   = (PI_Q62 + 64'd1800000000) / 64'd3600000000;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    function automatic logic [63:0] q62_to_q(input logic [63:0] a);
        return (a + (64'd1 << (61 - F))) >> (62 - F);
    endfunction

    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] sum;
        logic [63:0] t;
        int          sh;
        sum = 64'd0;
        if (i == 0)
            return QPI_Q62;
        for (int k = 0; k < 32; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh <= 62)
            begin
                t = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
                if (k % 2 == 1)
                    sum = sum - t;
                else
                    sum = sum + t;
            end
        end
        return sum;
    endfunction

    function automatic logic signed [DW-1:0] atan_q(input int i);
        return DW'(q62_to_q(atan_q62(i)));
    endfunction

    localparam logic signed [DW-1:0] GAIN_Q = DW'(q62_to_q(GAIN_Q62));

    // rounded half-away product of two QF values (magnitudes kept under 2^33)
    function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic [DW-1:0]   ma;
        logic [DW-1:0]   mb;
        logic [2*DW-1:0] p;
        logic [DW-1:0]   r;
        ma = a[DW-1] ? DW'(-a) : DW'(a);
        mb = b[DW-1] ? DW'(-b) : DW'(b);
        p  = ma * mb + ((2*DW)'(1) << (F - 1));
        r  = DW'(p >> F);
        return (a[DW-1] != b[DW-1]) ? -$signed(r) : $signed(r);
    endfunction

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } cord_t;

endpackage

/* rtl/core/hav_cell.sv */
// hav_cell: one registered CORDIC micro-rotation, rotation or vectoring mode.
// Depends on hav_pkg.
module hav_cell #(
    parameter int SHIFT  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic          clk,
    input  logic          en,
    input  hav_pkg::cord_t d,
    output hav_pkg::cord_t q
);
    localparam logic signed [hav_pkg::DW-1:0] A = hav_pkg::atan_q(SHIFT);
    hav_pkg::cord_t q_next;
    hav_pkg::cord_t q_reg;
    logic           pos;

    always_comb
    begin
        pos = VECTOR ? (d.y > 0) : (d.z >= 0);
        if (pos == !VECTOR)
        begin
            q_next.x = d.x - (d.y >>> SHIFT);
            q_next.y = d.y + (d.x >>> SHIFT);
            q_next.z = d.z - A;
        end
        else
        begin
            q_next.x = d.x + (d.y >>> SHIFT);
            q_next.y = d.y - (d.x >>> SHIFT);
            q_next.z = d.z + A;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

/* rtl/core/hav_sincos.sv */
// hav_sincos: angle reduction, degree-to-radian scaling and a chain of
// rotation cells. Depends on hav_pkg, hav_cell.
module hav_sincos (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [hav_pkg::HALF_W-1:0]   ang,
    output logic signed [hav_pkg::DW-1:0]       sin_q,
    output logic signed [hav_pkg::DW-1:0]       cos_q
);
    localparam int S = hav_pkg::STEPS;
    logic signed [hav_pkg::HALF_W:0] r;
    logic                            flip;
    logic signed [hav_pkg::HALF_W:0] r_reg;
    logic [31:0]                     m;
    logic [63:0]                     p;
    logic [63:0]                     a;
    hav_pkg::cord_t                  c0_next;
    hav_pkg::cord_t                  c0_reg;
    logic [S+1:0]                    flip_reg;
    hav_pkg::cord_t                  ch [S+1];

    // first stage: wrap into [-180, 180) and mirror into [-90, 90]
    always_comb
    begin
        r    = (hav_pkg::HALF_W+1)'(ang);
        flip = 1'b0;
        if (r >= hav_pkg::HALF_TURN)
            r = r - hav_pkg::FULL_TURN;
        if (r < -hav_pkg::HALF_TURN)
            r = r + hav_pkg::FULL_TURN;
        if (r > hav_pkg::QUARTER_TURN)
        begin
            r    = hav_pkg::HALF_TURN - r;
            flip = 1'b1;
        end
        if (r < -hav_pkg::QUARTER_TURN)
        begin
            r    = -hav_pkg::HALF_TURN - r;
            flip = 1'b1;
        end
    end

    // second stage: magnitude to radians in QF, sign restored
    always_comb
    begin
        m = r_reg[hav_pkg::HALF_W] ? 32'(-r_reg) : 32'(r_reg);
        p = 64'(m) * hav_pkg::DEG_MUL + (64'd1 << (61 - hav_pkg::F));
        a = p >> (62 - hav_pkg::F);
        c0_next.x = hav_pkg::GAIN_Q;
        c0_next.y = '0;
        c0_next.z = r_reg[hav_pkg::HALF_W] ? -$signed(hav_pkg::DW'(a))
                                           : $signed(hav_pkg::DW'(a));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r;
            c0_reg   <= c0_next;
            flip_reg <= {flip_reg[S:0], flip};
        end
    end

    assign ch[0] = c0_reg;
    for (genvar i = 0; i < S; i++)
    begin : g_cell
        hav_cell #(.SHIFT(i), .VECTOR(1'b0)) u_cell (
            .clk(clk), .en(en), .d(ch[i]), .q(ch[i+1]));
    end

    assign sin_q = ch[S].y;
    assign cos_q = flip_reg[S+1] ? -ch[S].x : ch[S].x;
endmodule

/* rtl/core/hav_sqrt.sv */
// hav_sqrt: pipelined restoring square root, one result bit per stage.
// Output is floor(sqrt(v * 2^F)). Depends on hav_pkg.
module hav_sqrt (
    input  logic                  clk,
    input  logic                  en,
    input  logic [hav_pkg::F:0]   v,
    output logic [hav_pkg::F:0]   root
);
    localparam int N  = hav_pkg::F + 1;        // result bits
    localparam int RW = N + 2;
    logic [2*N-1:0] rad_reg  [N+1];
    logic [RW-1:0]  rem_reg  [N+1];
    logic [N-1:0]   root_reg [N+1];

    assign rad_reg[0]  = (2*N)'(v) << hav_pkg::F;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial;
        always_comb
        begin
            rem_next = {rem_reg[j][RW-3:0], rad_reg[j][2*N-1 -: 2]};
            trial    = {root_reg[j], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j+1] <= rad_reg[j] << 2;
                if (rem_next >= trial)
                begin
                    rem_reg[j+1]  <= rem_next - trial;
                    root_reg[j+1] <= {root_reg[j][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j+1]  <= rem_next;
                    root_reg[j+1] <= {root_reg[j][N-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[N];
endmodule

/* rtl/core/haversine_distance_unit.sv */
// haversine_distance_unit: top level of the great-circle distance pipeline.
// Depends on hav_pkg, hav_sincos, hav_sqrt, hav_cell.
//
//   channel   direction  handshake          payload
//   in        request    in_valid/in_stall  lat_a lon_a lat_b lon_b
//   out       result     out_valid/out_stall distance_mm
//   config    write      cfg_we             cfg_data (earth_radius_m)
//
// One request per cycle while in_stall is low; a request passes a 32-cell CORDIC
// rotation chain, the 31-stage square root and a 32-cell CORDIC vectoring chain.
// The whole pipeline advances only while the output register is free or
// being taken, so a stall freezes every stage and no request is lost.
// Reset clears the valid bits of the pipeline and loads the default radius.
module haversine_distance_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [34:0]        distance_mm,
    input  logic               cfg_we,
    input  logic [22:0]        cfg_data
);
    localparam int DW  = hav_pkg::DW;
    localparam int F   = hav_pkg::F;
    localparam int S   = hav_pkg::STEPS;
    // LAT terms in order: sincos, products, sqrt, vector input, vector chain, scale
    localparam int LAT = 2 + S + 3 + (F + 1) + 1 + S + 2;

    logic              en;
    logic [LAT-1:0]    vld_reg;
    logic [22:0]       radius_reg;

    // a stalled output holds everything; otherwise the chain flows
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= 23'd6371000;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
            if (cfg_we)
                radius_reg <= cfg_data;
        end
    end

    // angles in half-units
    logic signed [hav_pkg::HALF_W-1:0] ang_a, ang_b, ang_dl, ang_do;
    assign ang_a  = hav_pkg::HALF_W'(lat_a) <<< 1;
    assign ang_b  = hav_pkg::HALF_W'(lat_b) <<< 1;
    assign ang_dl = hav_pkg::HALF_W'(lat_b) - hav_pkg::HALF_W'(lat_a);
    assign ang_do = hav_pkg::HALF_W'(lon_b) - hav_pkg::HALF_W'(lon_a);

    logic signed [DW-1:0] sa, ca, sb, cb, sdl, sdo, unused_c1, unused_c2;
    hav_sincos u_sa (.clk(clk), .en(en), .ang(ang_a),  .sin_q(sa),  .cos_q(ca));
    hav_sincos u_sb (.clk(clk), .en(en), .ang(ang_b),  .sin_q(sb),  .cos_q(cb));
    hav_sincos u_dl (.clk(clk), .en(en), .ang(ang_dl), .sin_q(sdl), .cos_q(unused_c1));
    hav_sincos u_do (.clk(clk), .en(en), .ang(ang_do), .sin_q(sdo), .cos_q(unused_c2));

    // products: at most one multiply per register, then the clamped sum
    logic signed [DW-1:0] p_dl_reg, p_cc_reg, p_do_reg, p_dl2_reg, p_x_reg;
    logic [F:0]           h_reg;
    logic signed [DW+1:0] h_sum;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_dl_reg  <= hav_pkg::mulq(sdl, sdl);
            p_cc_reg  <= hav_pkg::mulq(ca, cb);
            p_do_reg  <= hav_pkg::mulq(sdo, sdo);
            p_dl2_reg <= p_dl_reg;
            p_x_reg   <= hav_pkg::mulq(p_cc_reg, p_do_reg);
            if (h_sum < 0)
                h_reg <= '0;
            else if (h_sum > (DW+2)'(1) <<< F)
                h_reg <= (F+1)'(1) << F;
            else
                h_reg <= (F+1)'(h_sum);
        end
    end
    assign h_sum = (DW+2)'(p_dl2_reg) + (DW+2)'(p_x_reg);

    logic [F:0] omh, ry, rx;
    assign omh = ((F+1)'(1) << F) - h_reg;
    hav_sqrt u_sy (.clk(clk), .en(en), .v(h_reg), .root(ry));
    hav_sqrt u_sx (.clk(clk), .en(en), .v(omh),   .root(rx));

    // vectoring chain
    hav_pkg::cord_t v0_reg;
    hav_pkg::cord_t vc [S+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg.x <= DW'(rx);
            v0_reg.y <= DW'(ry);
            v0_reg.z <= '0;
        end
    end
    assign vc[0] = v0_reg;
    for (genvar i = 0; i < S; i++)
    begin : g_vec
        hav_cell #(.SHIFT(i), .VECTOR(1'b1)) u_cell (
            .clk(clk), .en(en), .d(vc[i]), .q(vc[i+1]));
    end

    // scale: c * (radius*1000), rounded, saturated
    logic [DW-1:0]  c_reg;
    logic [32:0]    rk;
    logic [DW+32:0] prod;
    logic [DW+32:0] rnd;
    logic [34:0]    dist_reg;
    assign rk   = 33'(radius_reg) * 33'd1000;
    assign prod = (DW+33)'(c_reg) * (DW+33)'(rk);
    assign rnd  = (prod + ((DW+33)'(1) << (F - 1))) >> F;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg    <= (vc[S].z < 0) ? '0 : DW'(vc[S].z <<< 1);
            dist_reg <= (rnd > (DW+33)'(hav_pkg::DIST_MAX)) ? hav_pkg::DIST_MAX
                                                            : 35'(rnd);
        end
    end

    assign out_valid   = vld_reg[LAT-1];
    assign distance_mm = dist_reg;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance_mm))
        else $error("result changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !in_valid && !out_valid |=> !vld_reg[0])
        else $error("phantom request entered");
`endif
endmodule

/* tb/tb_haversine_distance_unit.sv */
// tb_haversine_distance_unit: self-checking testbench for the haversine distance unit.
// It predicts each distance with its own fixed-point model and compares results in order.
// Depends on haversine_distance_unit and hav_pkg.
`timescale 1ns / 100ps

module tb_haversine_distance_unit;

    // Fixed-point constants for the predictor (Q62 sources, rounded to Q30)
    localparam int                FRAC       = 30;
    localparam int                ITERS      = 32;
    localparam longint unsigned   PI_Q62     = 64'hC90FDAA22168C235;
    localparam longint unsigned   QPI_Q62    = 64'h3243F6A8885A308D;
    localparam longint unsigned   GAIN_Q62   = 64'd2800459870029452953;
    localparam longint            TURN_HU    = 64'sd7200000000;
    localparam longint            HALF_HU    = 64'sd3600000000;
    localparam longint            QUART_HU   = 64'sd1800000000;
    localparam longint unsigned   MM_MAX     = 64'd34359738367;
    localparam logic [22:0]       RADIUS_RST = 23'd6371000;
    localparam int                LAT_MAX    = 900000000;
    localparam int                LON_MAX    = 1800000000;
    localparam int                DRAIN_CYC  = 150;   // comfortably above the pipeline depth LAT
    localparam int                IDLE_PCT   = 28;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               out_valid;
    logic               out_stall;
    logic [34:0]        distance_mm;
    logic               cfg_we;
    logic [22:0]        cfg_data;

    haversine_distance_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .lat_a       (lat_a),
        .lon_a       (lon_a),
        .lat_b       (lat_b),
        .lon_b       (lon_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance_mm (distance_mm),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    // Shadow copy of the radius register and the queue of predicted distances
    logic [22:0]     radius_m;
    longint unsigned dist_queue[$];
    int              n_errors;
    int              n_requests;
    int              n_results;
    bit              idle_off;      // long stretch with no idling on either side
    int              hold_request;  // receiver hold-off length asked by a test

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // atan(2^-i) in Q30, series taken in Q62 then rounded half up
    function automatic longint atan_q30(input int i);
        longint unsigned acc;
        longint unsigned term;
        int              sh;
        acc = 0;
        if (i == 0)
            acc = QPI_Q62;
        else
        begin
            for (int k = 0; k < 32; k++)
            begin
                sh = i * (2 * k + 1);
                if (sh <= 62)
                begin
                    term = (64'd1 << (62 - sh)) / longint'(2 * k + 1);
                    if (k % 2 == 1)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
            end
        end
        return longint'((acc + (64'd1 << 31)) >> 32);
    endfunction

    // Q30 product, rounded half away from zero
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        logic [127:0]    p;
        longint          r;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        p  = 128'(ma) * 128'(mb) + (128'd1 << (FRAC - 1));
        r  = longint'(p >> FRAC);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Sine and cosine of an angle given in half-units (0.5e-7 degree)
    task automatic sin_cos(input longint half_units, output longint s, output longint c);
        longint          r;
        bit              mirrored;
        longint unsigned scale;
        longint unsigned ang;
        longint unsigned mr;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          a;
        r        = half_units % TURN_HU;
        mirrored = 0;
        scale    = (PI_Q62 + 64'd1800000000) / 64'd3600000000;
        if (r >= HALF_HU)
            r = r - TURN_HU;
        if (r < -HALF_HU)
            r = r + TURN_HU;
        if (r > QUART_HU)
        begin
            r = HALF_HU - r;
            mirrored = 1;
        end
        if (r < -QUART_HU)
        begin
            r = -HALF_HU - r;
            mirrored = 1;
        end
        mr  = (r < 0) ? longint'(-r) : r;
        ang = (mr * scale + (64'd1 << 31)) >> 32;
        z   = (r < 0) ? -longint'(ang) : longint'(ang);
        x   = longint'((GAIN_Q62 + (64'd1 << 31)) >> 32);
        y   = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            a  = atan_q30(i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - a;
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + a;
            end
        end
        s = y;
        c = mirrored ? -x : x;
    endtask

    task automatic predict_distance(input logic signed [30:0] la, input logic signed [31:0] oa,
                                    input logic signed [30:0] lb, input logic signed [31:0] ob,
                                    output longint unsigned dist_mm);
        longint       sa, ca, sb, cb, sdl, sdo, unused;
        longint       h, x, y, z, dx, dy, a, one;
        logic [127:0] p;
        sin_cos(2 * longint'(la), sa, ca);
        sin_cos(2 * longint'(lb), sb, cb);
        sin_cos(longint'(lb) - longint'(la), sdl, unused);
        sin_cos(longint'(ob) - longint'(oa), sdo, unused);
        one = longint'(1) << FRAC;
        h = q30_mul(sdl, sdl) + q30_mul(q30_mul(ca, cb), q30_mul(sdo, sdo));
        if (h < 0)
            h = 0;
        if (h > one)
            h = one;
        y = int_sqrt(longint'(h) << FRAC);
        x = int_sqrt(longint'(one - h) << FRAC);
        z = 0;
        // vectoring pass gives atan2(sqrt h, sqrt(1-h))
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            a  = atan_q30(i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + a;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - a;
            end
        end
        z = 2 * z;
        if (z < 0)
            z = 0;
        p = 128'(z) * 128'(longint'(radius_m) * 1000) + (128'd1 << (FRAC - 1));
        p = p >> FRAC;
        dist_mm = (p > 128'(MM_MAX)) ? MM_MAX : longint'(p);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic send_request(input logic signed [30:0] la, input logic signed [31:0] oa,
                                input logic signed [30:0] lb, input logic signed [31:0] ob);
        longint unsigned d;
        // random idle cycles before the request
        while (!idle_off && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a    <= la;
        lon_a    <= oa;
        lat_b    <= lb;
        lon_b    <= ob;
        do
            @(posedge clk);
        while (in_stall);
        predict_distance(la, oa, lb, ob, d);
        dist_queue.push_back(d);
        n_requests++;
    endtask

    task automatic end_requests();
        in_valid <= 1'b0;
    endtask

    // Wait until every predicted result has arrived, then a margin beyond the pipeline depth
    task automatic drain();
        end_requests();
        while (dist_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_radius(input logic [22:0] r);
        cfg_we   <= 1'b1;
        cfg_data <= r;
        @(posedge clk);
        cfg_we   <= 1'b0;
        radius_m  = r;
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'(int'($urandom_range(2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        return 32'(longint'($urandom_range(2 * LON_MAX)) - LON_MAX);
    endfunction

    // Mostly valid coordinate pairs, with near, antipodal and raw bit noise mixed in
    task automatic send_random_pair();
        logic signed [30:0] la, lb;
        logic signed [31:0] oa, ob;
        int                 kind;
        kind = $urandom_range(99);
        la = rand_lat();
        oa = rand_lon();
        lb = rand_lat();
        ob = rand_lon();
        if (kind < 15)
        begin
            lb = la + 31'(int'($urandom_range(2000)) - 1000);
            ob = oa + 32'(int'($urandom_range(2000)) - 1000);
        end
        else if (kind < 25)
        begin
            lb = -la;
            ob = oa + 32'(LON_MAX);
        end
        else if (kind < 40)
        begin
            la = 31'($urandom);
            oa = 32'($urandom);
            lb = 31'($urandom);
            ob = 32'($urandom);
        end
        send_request(la, oa, lb, ob);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    int hold_left;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (dist_queue.size() == 0)
                report_mismatch("unexpected distance_mm", distance_mm, 0);
            else if (64'(distance_mm) != dist_queue[0])
                report_mismatch("distance_mm", distance_mm, dist_queue.pop_front());
            else
                void'(dist_queue.pop_front());
            n_results++;
        end
    end

    // Receiver side: a requested hold-off is counted down here, else random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left  = 0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !idle_off && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of each field, equal points, poles, antimeridian, out-of-range wrap
    task automatic test_directed();
        send_request(0, 0, 0, 0);
        send_request(31'(LAT_MAX), 0, -31'(LAT_MAX), 0);
        send_request(31'(LAT_MAX), 32'(LON_MAX), 31'(LAT_MAX), -32'(LON_MAX));
        send_request(0, -32'(LON_MAX), 0, 32'(LON_MAX));
        send_request(0, 0, 0, 32'(LON_MAX));
        send_request(0, 0, 0, 32'(LON_MAX / 2));
        send_request(12345678, 98765432, 12345679, 98765433);
        send_request(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000);
        send_request(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
        send_request(-1, -1, 1, 1);
        send_request(515000000, -1200000, 407000000, -740000000);
        send_request(-338000000, 1512000000, 515000000, -1200000);
        send_request(31'(LAT_MAX), 0, 31'(LAT_MAX), 32'(LON_MAX));
        send_request(-31'(LAT_MAX), 100, 0, 0);
        send_request(31'h7FFFFFFF ^ 31'h2AAAAAAA, 32'h55555555, 31'h2AAAAAAA, 32'hAAAAAAAA);
        drain();
    endtask

    // Radius extremes, zero radius, and a random radius, each with a short burst
    task automatic test_radius_settings();
        logic [22:0] radii[4];
        radii[0] = 23'd1;
        radii[1] = 23'h7FFFFF;
        radii[2] = 23'd0;
        radii[3] = 23'($urandom_range(1, 23'h7FFFFF));
        foreach (radii[i])
        begin
            write_radius(radii[i]);
            send_request(31'(LAT_MAX), 0, -31'(LAT_MAX), 0);
            send_request(0, 0, 0, 32'(LON_MAX));
            for (int n = 0; n < 40; n++)
                send_random_pair();
            drain();
        end
        write_radius(RADIUS_RST);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            idle_off = (n >= count / 3) && (n < count / 2);
            send_random_pair();
        end
        idle_off = 0;
        drain();
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_request = 400;
        for (int n = 0; n < 250; n++)
            send_random_pair();
        drain();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        lat_a        = '0;
        lon_a        = '0;
        lat_b        = '0;
        lon_b        = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        radius_m     = RADIUS_RST;
        n_errors     = 0;
        n_requests   = 0;
        n_results    = 0;
        idle_off     = 0;
        hold_request = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_radius_settings();
        test_backpressure();
        test_random(1100);
        write_radius(23'($urandom_range(1, 23'h7FFFFF)));
        test_random(100);

        $display("Covered %0d requests and %0d distances over six radius settings,",
                 n_requests, n_results);
        $display("with random idling, a long output hold-off and out-of-range inputs.");
        if (n_errors == 0 && dist_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", dist_queue.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
